>>> sv/lssr_pkg.sv
// ----------------------------------------------------------------------------
// lssr_pkg
// Types, codes and constants shared by the leg servo speed regulator.
// ----------------------------------------------------------------------------
package lssr_pkg;

  localparam int NumLegsDef = 6;

  localparam int PulseW   = 14;
  localparam int CfgIdxW  = 3;
  localparam int AngleW   = 9;

  localparam logic [7:0]        SetTargetCode = 8'h84;
  localparam logic [11:0]       MvLow         = 12'd100;
  localparam logic [11:0]       MvHigh        = 12'd3000;
  localparam logic [AngleW-1:0] AngleFull     = 9'd360;
  localparam logic [AngleW-1:0] AngleHigh     = 9'd270;
  localparam logic [AngleW-1:0] AngleLow      = 9'd90;
  localparam logic [AngleW-1:0] TgtResetEven  = 9'd10;
  localparam logic [AngleW-1:0] TgtResetOdd   = 9'd160;

  // Reciprocals for the constant divisions, both scaled by 2^24.
  localparam logic [21:0] PosRecip  = 22'd2081970;  // 360 / 2901
  localparam logic [15:0] TgtRecip  = 16'd46603;    // 1 / 360
  localparam logic [11:0] PosDivisor = 12'd2901;

  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_SAMPLE     = 2'd1,
    CMD_STOP_ALL   = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_FAST = 2'd1,
    CLS_STOP = 2'd2,
    CLS_SLOW = 2'd3
  } cls_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FWD_FAST = 3'd0,
    CFG_FWD_SLOW = 3'd1,
    CFG_HALT     = 3'd2,
    CFG_BWD_SLOW = 3'd3,
    CFG_BWD_FAST = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  leg;
    logic [11:0] sample_millivolts;
    logic [15:0] target_degrees;
  } in_item_t;

  typedef struct packed {
    logic [7:0] command_code;
    logic [2:0] channel;
    logic [6:0] pulse_low7;
    logic [6:0] pulse_high7;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [PulseW-1:0] fwd_fast;
    logic [PulseW-1:0] fwd_slow;
    logic [PulseW-1:0] halt;
    logic [PulseW-1:0] bwd_slow;
    logic [PulseW-1:0] bwd_fast;
  } cfg_t;

  // Partial results computed on the way into the input register.
  typedef struct packed {
    logic [11:0]       mv_ofs;
    logic [AngleW-1:0] pos_est;
    logic [7:0]        tgt_est;
  } pre_t;

  typedef struct packed {
    logic [AngleW-1:0] tgt_red;
    cls_e              cls;
    logic              fwd;
  } cls_res_t;

endpackage

>>> sv/leg_servo_speed_regulator_core.sv
// ----------------------------------------------------------------------------
// leg_servo_speed_regulator_core
// Speed regulator for continuous-rotation leg servos: stores leg targets,
// classifies position samples and sends set-target commands on class change.
//
//  channel | direction | signals                          | transfer when
//  --------+-----------+----------------------------------+---------------------
//  in      | input     | in_valid_i, in_stall_o, in_data_i | valid high, stall low
//  out     | output    | out_valid_o, out_stall_i, out_data_o | valid high, stall low
//  cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | both high
//
// One item is taken per cycle while the input is not stalled. An item is held
// in the input register and its result in the output register. A stop-all
// sends a stop command to each of the NUM_LEGS legs, one per cycle while the
// output is not stalled. Reset loads the default pulse values, targets of
// 10 and 160 alternately, no class sent and servos enabled. A stalled output
// holds its result while one more item waits in the input register.
// ----------------------------------------------------------------------------
module leg_servo_speed_regulator_core
  import lssr_pkg::*;
#(
  parameter int NUM_LEGS = NumLegsDef
)
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PulseW-1:0]  cfg_data_i
);

  localparam int LegW = $clog2(NUM_LEGS);
  localparam logic [LegW-1:0] LastLeg = LegW'(NUM_LEGS - 1);

  cfg_t      cfg;
  pre_t      pre;
  cls_res_t  res;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_q;
  pre_t      pre_q;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      burst_q, burst_d;
  logic [LegW-1:0] burst_chan_q, burst_chan_d;

  logic [AngleW-1:0] target_q [NUM_LEGS];
  cls_e              class_q  [NUM_LEGS];
  logic              servos_on_q, servos_on_d;

  logic [LegW-1:0]   leg_idx;
  logic              leg_ok;
  logic              out_taken;
  logic              consume;
  logic              in_take;
  logic              emit;
  logic              tgt_we;
  logic              cls_we;
  logic [PulseW-1:0] pulse;

  lssr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lssr_prescale u_pre (
    .item_i (in_data_i),
    .pre_o  (pre)
  );

  assign leg_idx = LegW'(in_q.leg);
  assign leg_ok  = 32'(in_q.leg) < NUM_LEGS;

  lssr_classify #(
    .NUM_LEGS (NUM_LEGS)
  ) u_cls (
    .item_i   (in_q),
    .pre_i    (pre_q),
    .target_i (target_q[leg_idx]),
    .res_o    (res)
  );

  assign cfg_ready_o = 1'b1;

  // The output register is free for a new result once its current one is
  // taken, except while a stop-all is still being sent.
  assign out_taken  = out_valid_q && !out_stall_i;
  assign consume    = in_valid_q && !burst_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    case (res.cls)
      CLS_FAST: pulse = res.fwd ? cfg.fwd_fast : cfg.bwd_fast;
      CLS_SLOW: pulse = res.fwd ? cfg.fwd_slow : cfg.bwd_slow;
      default:  pulse = cfg.halt;
    endcase
  end

  always_comb begin
    in_valid_d   = in_take ? 1'b1 : (consume ? 1'b0 : in_valid_q);
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    burst_d      = burst_q;
    burst_chan_d = burst_chan_q;
    servos_on_d  = servos_on_q;
    emit         = 1'b0;
    tgt_we       = 1'b0;
    cls_we       = 1'b0;

    if (out_taken) begin
      out_valid_d = 1'b0;
    end

    if (burst_q && out_taken) begin
      out_valid_d           = 1'b1;
      out_d.command_code    = SetTargetCode;
      out_d.channel         = 3'(burst_chan_q);
      out_d.pulse_low7      = cfg.halt[6:0];
      out_d.pulse_high7     = cfg.halt[13:7];
      out_d.last            = (burst_chan_q == LastLeg);
      if (burst_chan_q == LastLeg) begin
        burst_d = 1'b0;
      end else begin
        burst_chan_d = burst_chan_q + LegW'(1);
      end
    end else if (consume) begin
      case (cmd_e'(in_q.cmd))
        CMD_SET_TARGET: begin
          servos_on_d = 1'b1;
          tgt_we      = leg_ok;
        end
        CMD_SAMPLE: begin
          emit   = servos_on_q && leg_ok && (res.cls != class_q[leg_idx]);
          cls_we = emit;
          if (emit) begin
            out_valid_d        = 1'b1;
            out_d.command_code = SetTargetCode;
            out_d.channel      = in_q.leg;
            out_d.pulse_low7   = pulse[6:0];
            out_d.pulse_high7  = pulse[13:7];
            out_d.last         = 1'b1;
          end
        end
        CMD_STOP_ALL: begin
          servos_on_d        = 1'b0;
          out_valid_d        = 1'b1;
          out_d.command_code = SetTargetCode;
          out_d.channel      = 3'd0;
          out_d.pulse_low7   = cfg.halt[6:0];
          out_d.pulse_high7  = cfg.halt[13:7];
          out_d.last         = 1'b0;
          burst_d            = 1'b1;
          burst_chan_d       = LegW'(1);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      burst_q      <= 1'b0;
      burst_chan_q <= '0;
      servos_on_q  <= 1'b1;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      burst_q      <= burst_d;
      burst_chan_q <= burst_chan_d;
      servos_on_q  <= servos_on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q  <= in_data_i;
      pre_q <= pre;
    end
    out_q <= out_d;
  end

  for (genvar g = 0; g < NUM_LEGS; g++) begin : g_leg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        target_q[g] <= (g % 2 == 1) ? TgtResetOdd : TgtResetEven;
        class_q[g]  <= CLS_NONE;
      end else begin
        if (tgt_we && leg_idx == LegW'(g)) begin
          target_q[g] <= res.tgt_red;
        end
        if (cls_we && leg_idx == LegW'(g)) begin
          class_q[g] <= res.cls;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/lssr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lssr_cfg_regs
// Pulse value registers written through the configuration port.
// ----------------------------------------------------------------------------
module lssr_cfg_regs
  import lssr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PulseW-1:0]  cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FWD_FAST: cfg_d.fwd_fast = cfg_data_i;
        CFG_FWD_SLOW: cfg_d.fwd_slow = cfg_data_i;
        CFG_HALT:     cfg_d.halt     = cfg_data_i;
        CFG_BWD_SLOW: cfg_d.bwd_slow = cfg_data_i;
        CFG_BWD_FAST: cfg_d.bwd_fast = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_fast <= 14'd6500;
      cfg_q.fwd_slow <= 14'd6300;
      cfg_q.halt     <= 14'd6000;
      cfg_q.bwd_slow <= 14'd5700;
      cfg_q.bwd_fast <= 14'd5500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lssr_prescale.sv
// ----------------------------------------------------------------------------
// lssr_prescale
// Clamps the sample and forms the reciprocal quotient estimates for the
// position scaling and the target reduction ahead of the input register.
// ----------------------------------------------------------------------------
module lssr_prescale
  import lssr_pkg::*;
(
  input  in_item_t item_i,
  output pre_t     pre_o
);

  logic [11:0] mv_clamped;
  logic [11:0] mv_ofs;
  logic [15:0] tgt_m1;
  logic [33:0] pos_prod;
  logic [31:0] tgt_prod;

  always_comb begin
    if (item_i.sample_millivolts < MvLow) begin
      mv_clamped = MvLow;
    end else if (item_i.sample_millivolts > MvHigh) begin
      mv_clamped = MvHigh;
    end else begin
      mv_clamped = item_i.sample_millivolts;
    end
    mv_ofs = mv_clamped - MvLow;
    tgt_m1 = item_i.target_degrees - 16'd1;
  end

  // Both estimates are the true quotient or one below it.
  assign pos_prod = 34'(mv_ofs) * 34'(PosRecip);
  assign tgt_prod = 32'(tgt_m1) * 32'(TgtRecip);

  assign pre_o.mv_ofs  = mv_ofs;
  assign pre_o.pos_est = pos_prod[32:24];
  assign pre_o.tgt_est = tgt_prod[31:24];

endmodule

>>> sv/lssr_classify.sv
// ----------------------------------------------------------------------------
// lssr_classify
// Finishes the position angle and target reduction and picks the speed
// class of a leg from its position and target.
// ----------------------------------------------------------------------------
module lssr_classify
  import lssr_pkg::*;
#(
  parameter int NUM_LEGS = NumLegsDef
)
(
  input  in_item_t          item_i,
  input  pre_t              pre_i,
  input  logic [AngleW-1:0] target_i,
  output cls_res_t          res_o
);

  logic [20:0]       pos_num;
  logic [21:0]       pos_back;
  logic [21:0]       pos_rem;
  logic [AngleW-1:0] pos_raw;
  logic [AngleW-1:0] pos;
  logic [15:0]       tgt_m1;
  logic [16:0]       tgt_back;
  logic [16:0]       tgt_rem;
  logic [16:0]       tgt_rem_fix;
  logic              fwd;

  always_comb begin
    // Position: remainder check lifts the estimate by one where needed.
    pos_num  = 21'(pre_i.mv_ofs) * 21'd360;
    pos_back = 22'(pre_i.pos_est) * 22'(PosDivisor);
    pos_rem  = 22'(pos_num) - pos_back;
    pos_raw  = (pos_rem >= 22'(PosDivisor)) ? pre_i.pos_est + 9'd1 : pre_i.pos_est;

    fwd = 32'(item_i.leg) >= NUM_LEGS / 2;
    pos = fwd ? AngleFull - pos_raw : pos_raw;

    // Target: ((t - 1) mod 360) + 1 for targets above a full turn.
    tgt_m1      = item_i.target_degrees - 16'd1;
    tgt_back    = 17'(pre_i.tgt_est) * 17'd360;
    tgt_rem     = 17'(tgt_m1) - tgt_back;
    tgt_rem_fix = (tgt_rem >= 17'(AngleFull)) ? tgt_rem - 17'(AngleFull) : tgt_rem;
    if (item_i.target_degrees > 16'(AngleFull)) begin
      res_o.tgt_red = AngleW'(tgt_rem_fix + 17'd1);
    end else begin
      res_o.tgt_red = AngleW'(item_i.target_degrees);
    end

    if (pos > target_i) begin
      res_o.cls = (pos > AngleHigh && target_i < AngleHigh) ? CLS_FAST : CLS_STOP;
    end else begin
      res_o.cls = (pos > AngleHigh || pos < AngleLow) ? CLS_FAST : CLS_SLOW;
    end
    res_o.fwd = fwd;
  end

endmodule

>>> sv/lssr_checker.sv
// ----------------------------------------------------------------------------
// lssr_checker
// Port-level checks on the speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
module lssr_checker
  import lssr_pkg::*;
#(
  parameter int NUM_LEGS = NumLegsDef
)
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_item_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_data_o
);

  // A held-off input transfer keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.command_code == SetTargetCode)
    else $error("result command code is not set-target");

  a_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.channel) < NUM_LEGS)
    else $error("result channel beyond the last leg");

  // A stop-all sequence continues without a gap until its final command.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      out_valid_o && out_data_o.channel == $past(out_data_o.channel) + 3'd1)
    else $error("stop-all sequence broken");

endmodule

bind leg_servo_speed_regulator_core lssr_checker #(
  .NUM_LEGS (NUM_LEGS)
) u_lssr_checker (.*);

>>> sim/leg_servo_speed_regulator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_servo_speed_regulator_core_checker
// Watches the input, output and register channels of the leg servo speed
// regulator. It keeps its own copy of the leg targets, the speed classes
// last sent, the enable flag and the pulse registers, works out the servo
// commands that each input transfer causes, and compares every output
// transfer field by field with the oldest command still due.
// ----------------------------------------------------------------------------
module leg_servo_speed_regulator_core_checker
  import lssr_pkg::*;
#(
  parameter int NUM_LEGS = NumLegsDef
)
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PulseW-1:0]  cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  cfg_t              pulse_cfg;
  logic [AngleW-1:0] leg_tgt [NUM_LEGS];
  cls_e              leg_cls [NUM_LEGS];
  logic              servos_on;
  out_item_t         due_cmds_q [$];

  function automatic out_item_t servo_cmd(input int unsigned chan,
                                          input logic [PulseW-1:0] pulse,
                                          input logic fin);
    out_item_t c;
    c.command_code = SetTargetCode;
    c.channel      = chan[2:0];
    c.pulse_low7   = pulse[6:0];
    c.pulse_high7  = pulse[13:7];
    c.last         = fin;
    return c;
  endfunction

  // Angle of a leg from its position voltage; forward legs count the other way.
  function automatic int unsigned leg_angle(input logic [11:0] mv, input bit fwd);
    int unsigned m;
    int unsigned a;
    m = 32'(mv);
    if (m < 32'(MvLow)) m = 32'(MvLow);
    if (m > 32'(MvHigh)) m = 32'(MvHigh);
    a = (m - 32'(MvLow)) * 32'(AngleFull) / 32'(PosDivisor);
    if (fwd) a = 32'(AngleFull) - a;
    return a;
  endfunction

  task automatic regulate_item(input in_item_t it);
    int unsigned       leg;
    int unsigned       tgt;
    int unsigned       pos;
    int unsigned       t;
    bit                fwd;
    cls_e              cls;
    logic [PulseW-1:0] pulse;
    leg = 32'(it.leg);
    case (cmd_e'(it.cmd))
      CMD_SET_TARGET: begin
        servos_on = 1'b1;
        tgt = 32'(it.target_degrees);
        if (tgt > 32'(AngleFull)) tgt = ((tgt - 1) % 32'(AngleFull)) + 1;
        if (leg < NUM_LEGS) leg_tgt[leg] = tgt[AngleW-1:0];
      end
      CMD_SAMPLE: begin
        if (servos_on && leg < NUM_LEGS) begin
          fwd = leg >= NUM_LEGS / 2;
          pos = leg_angle(it.sample_millivolts, fwd);
          t   = 32'(leg_tgt[leg]);
          if (pos > t) begin
            cls = (pos > 32'(AngleHigh) && t < 32'(AngleHigh)) ? CLS_FAST : CLS_STOP;
          end else begin
            cls = (pos > 32'(AngleHigh) || pos < 32'(AngleLow)) ? CLS_FAST : CLS_SLOW;
          end
          // A command goes out only when the class of the leg changes.
          if (cls != leg_cls[leg]) begin
            leg_cls[leg] = cls;
            case (cls)
              CLS_FAST: pulse = fwd ? pulse_cfg.fwd_fast : pulse_cfg.bwd_fast;
              CLS_SLOW: pulse = fwd ? pulse_cfg.fwd_slow : pulse_cfg.bwd_slow;
              default:  pulse = pulse_cfg.halt;
            endcase
            due_cmds_q.push_back(servo_cmd(leg, pulse, 1'b1));
          end
        end
      end
      CMD_STOP_ALL: begin
        for (int i = 0; i < NUM_LEGS; i++) begin
          due_cmds_q.push_back(servo_cmd(i, pulse_cfg.halt, i == NUM_LEGS - 1));
        end
        servos_on = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      pulse_cfg = '{fwd_fast: 14'd6500, fwd_slow: 14'd6300, halt: 14'd6000,
                    bwd_slow: 14'd5700, bwd_fast: 14'd5500};
      for (int i = 0; i < NUM_LEGS; i++) begin
        leg_tgt[i] = (i % 2 == 1) ? TgtResetOdd : TgtResetEven;
        leg_cls[i] = CLS_NONE;
      end
      servos_on = 1'b1;
      due_cmds_q.delete();
      pending_o = 0;
    end else begin
      // A result never leaves at the edge that transfers its item, so compare before predicting.
      if (out_valid_i && !out_stall_i) begin
        if (due_cmds_q.size() == 0) begin
          $error("servo command on channel %0d with none due", out_data_i.channel);
          errors_o++;
        end else begin
          e = due_cmds_q.pop_front();
          check_field("command_code", 32'(e.command_code), 32'(out_data_i.command_code));
          check_field("channel", 32'(e.channel), 32'(out_data_i.channel));
          check_field("pulse_low7", 32'(e.pulse_low7), 32'(out_data_i.pulse_low7));
          check_field("pulse_high7", 32'(e.pulse_high7), 32'(out_data_i.pulse_high7));
          check_field("last", 32'(e.last), 32'(out_data_i.last));
          checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FWD_FAST: pulse_cfg.fwd_fast = cfg_data_i;
          CFG_FWD_SLOW: pulse_cfg.fwd_slow = cfg_data_i;
          CFG_HALT:     pulse_cfg.halt     = cfg_data_i;
          CFG_BWD_SLOW: pulse_cfg.bwd_slow = cfg_data_i;
          CFG_BWD_FAST: pulse_cfg.bwd_fast = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) regulate_item(in_data_i);
      pending_o = due_cmds_q.size();
    end
  end

endmodule

>>> sim/leg_servo_speed_regulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_servo_speed_regulator_core_tb
// Drives targets, position samples, stop-all and unused commands into the
// regulator under several pulse register settings, with random idling on
// both sides, one long output hold-off and full drains. A separate checker
// predicts the servo commands and counts mismatches.
// ----------------------------------------------------------------------------
module leg_servo_speed_regulator_core_tb
  import lssr_pkg::*;
;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 80;
  localparam int RandPerPhase = 97;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  in_item_t           in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [PulseW-1:0]  cfg_data    = '0;

  int  errors;
  int  pending;
  int  checked;
  int  cycles     = 0;
  int  items_sent = 0;
  int  settings   = 1;
  bit  quiet      = 1'b0;
  int  hold_token = 0;
  int  hold_seen  = 0;
  int  hold_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  leg_servo_speed_regulator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  leg_servo_speed_regulator_core_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // Output side: random stalls, or a long hold-off each time one is requested.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("leg_servo_speed_regulator_core_tb failed");
      $finish;
    end
  end

  function automatic in_item_t leg_item(input cmd_e c, input int unsigned leg,
                                        input int unsigned mv, input int unsigned tgt);
    in_item_t it;
    it.cmd               = c;
    it.leg               = leg[2:0];
    it.sample_millivolts = mv[11:0];
    it.target_degrees    = tgt[15:0];
    return it;
  endfunction

  function automatic in_item_t rand_item(input int stop_pct);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < stop_pct) it.cmd = CMD_STOP_ALL;
    else if (r < stop_pct + 20) it.cmd = CMD_SET_TARGET;
    else if (r < stop_pct + 23) it.cmd = CMD_UNUSED;
    else it.cmd = CMD_SAMPLE;
    it.leg = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      0:       it.sample_millivolts = 12'($urandom_range(90, 110));
      1:       it.sample_millivolts = 12'($urandom_range(2990, 3010));
      2:       it.sample_millivolts = 12'($urandom_range(0, 4095));
      default: it.sample_millivolts = 12'($urandom_range(100, 3000));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    it.target_degrees = 16'($urandom_range(0, 65535));
      2:       it.target_degrees = 16'($urandom_range(265, 275));
      3:       it.target_degrees = 16'($urandom_range(85, 95));
      4:       it.target_degrees = 16'($urandom_range(355, 365));
      default: it.target_degrees = 16'($urandom_range(0, 360));
    endcase
    return it;
  endfunction

  // Offers one item until the edge that transfers it, then may pause the input.
  task automatic offer_item(input in_item_t it);
    bit taken;
    in_data  <= it;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Holds the input until every due command has arrived, then lets the
  // pipeline settle so that no target write is still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [PulseW-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready;
      @(posedge clk_i);
    end
  endtask

  task automatic write_pulses(input cfg_t c);
    write_reg(CFG_FWD_FAST, c.fwd_fast);
    write_reg(CFG_FWD_SLOW, c.fwd_slow);
    write_reg(CFG_HALT, c.halt);
    write_reg(CFG_BWD_SLOW, c.bwd_slow);
    write_reg(CFG_BWD_FAST, c.bwd_fast);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cfg_t pulses;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset pulse values.
    offer_item(leg_item(CMD_SAMPLE, 0, 0, 0));        // clamped low, fast backward
    offer_item(leg_item(CMD_SAMPLE, 0, 4095, 65535)); // clamped high, class unchanged
    offer_item(leg_item(CMD_SAMPLE, 1, 100, 0));
    offer_item(leg_item(CMD_SAMPLE, 1, 1500, 0));     // just past target, stop
    offer_item(leg_item(CMD_SAMPLE, 3, 100, 0));      // mirrored to 360, fast forward
    offer_item(leg_item(CMD_SAMPLE, 4, 3000, 0));
    offer_item(leg_item(CMD_SAMPLE, 4, 2000, 0));     // past target, stop
    offer_item(leg_item(CMD_SET_TARGET, 0, 4095, 65535));
    offer_item(leg_item(CMD_SET_TARGET, 3, 0, 361));
    offer_item(leg_item(CMD_SET_TARGET, 5, 0, 360));
    offer_item(leg_item(CMD_SET_TARGET, 2, 0, 270));
    offer_item(leg_item(CMD_SAMPLE, 2, 2400, 0));     // above 270 but target not below it
    offer_item(leg_item(CMD_SAMPLE, 0, 800, 0));
    offer_item(leg_item(CMD_SAMPLE, 5, 100, 0));      // position equals target
    offer_item(leg_item(CMD_SET_TARGET, 6, 0, 200));  // no such leg
    offer_item(leg_item(CMD_SAMPLE, 7, 1000, 0));     // no such leg
    offer_item(leg_item(CMD_UNUSED, 2, 4095, 65535));
    offer_item(leg_item(CMD_STOP_ALL, 0, 0, 0));
    offer_item(leg_item(CMD_SAMPLE, 1, 2900, 0));     // servos disabled
    offer_item(leg_item(CMD_SET_TARGET, 7, 0, 0));    // enables without storing
    offer_item(leg_item(CMD_SAMPLE, 1, 2900, 0));
    offer_item(leg_item(CMD_SET_TARGET, 1, 0, 0));
    offer_item(leg_item(CMD_SAMPLE, 1, 100, 0));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: pulses = '0;
        1: pulses = '1;
        2: pulses = '{fwd_fast: 14'h2aaa, fwd_slow: 14'h1555, halt: 14'h2aaa,
                      bwd_slow: 14'h1555, bwd_fast: 14'h2aaa};
        default: pulses = '{fwd_fast: 14'($urandom_range(0, 16383)),
                            fwd_slow: 14'($urandom_range(0, 16383)),
                            halt:     14'($urandom_range(0, 16383)),
                            bwd_slow: 14'($urandom_range(0, 16383)),
                            bwd_fast: 14'($urandom_range(0, 16383))};
      endcase
      write_pulses(pulses);
      settings++;
      quiet <= (p == 1);
      // Hold the output for a while and keep feeding stop-alls so the block fills up.
      if (p == 2) hold_token <= hold_token + 1;
      for (int k = 0; k < RandPerPhase; k++) begin
        if (p == 3 && k == RandPerPhase / 2) wait_drained();
        offer_item(rand_item((p == 2 && k < 30) ? 30 : 5));
      end
      wait_drained();
    end

    $display("Covered %0d items under %0d pulse settings, %0d servo commands compared.",
             items_sent, settings, checked);
    $display("Included clamping, target wrap, mirrored legs, stop-all and a long hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("leg_servo_speed_regulator_core_tb passed");
    end else begin
      $display("leg_servo_speed_regulator_core_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lssr_pkg.sv
sv/lssr_cfg_regs.sv
sv/lssr_prescale.sv
sv/lssr_classify.sv
sv/leg_servo_speed_regulator_core.sv
sv/lssr_checker.sv
sim/leg_servo_speed_regulator_core_checker.sv
sim/leg_servo_speed_regulator_core_tb.sv
